// ===== rtl/core/emrg_pkg.sv =====
// Shared types, constants and a helper function for the Eller maze row generator.
package emrg_pkg;

  localparam int ROW_W     = 32;
  localparam int ROW_IDX_W = 5;
  localparam int LABEL_W   = 5;
  localparam int CFG_W     = 6;

  localparam logic [CFG_W-1:0] CFG_COLS_RESET = 6'd32;

  typedef struct packed {
    logic              first_row;
    logic              last_row;
    logic [ROW_W-2:0]  right_random;
    logic [ROW_W-1:0]  down_random;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] right_walls;
    logic [ROW_W-1:0] bottom_walls;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic fresh_step;
    logic join_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_last;
  } dp_status_t;

  // Lowest label whose bit is clear; zero when every label is taken.
  function automatic logic [LABEL_W-1:0] first_free(input logic [ROW_W-1:0] used);
    logic [LABEL_W-1:0] res;
    res = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!used[i]) begin
        res = LABEL_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/eller_maze_row_generator.sv =====
// Eller maze row generator: one maze row of right and bottom walls per input item.
// Each item is loaded, then swept twice over the N columns in use (1 to MAX_COLS): a
// first column sweep hands out fresh set labels, and a second column sweep places right
// walls, merges sets and picks the down passage of each run; then the result register is
// written, which waits while a previous result is still stalled. The merge works column by
// column against the shared set label array. A finished result waits in its output
// register, so the next item is taken while it waits.
module eller_maze_row_generator
  import emrg_pkg::*;
#(
  parameter int MAX_COLS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  emrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  emrg_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .status      (status),
    .out_item    (out_item)
  );

endmodule

// ===== rtl/core/emrg_ctrl.sv =====
// Sequencer for the Eller maze row generator: load, label sweep, join sweep, emit.
module emrg_ctrl
  import emrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRESH,
    S_JOIN,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load       = in_valid;
      S_FRESH: cmd.fresh_step = 1'b1;
      S_JOIN:  cmd.join_step  = 1'b1;
      S_EMIT:  cmd.emit       = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_FRESH;
        end
        S_FRESH: begin
          if (status.at_last) state_r <= S_JOIN;
        end
        S_JOIN: begin
          if (status.at_last) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.emit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/emrg_dp.sv =====
// Datapath of the Eller maze row generator: set labels, wall vectors and the result register.
module emrg_dp
  import emrg_pkg::*;
#(
  parameter int MAX_COLS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  in_item_t         in_item,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status,
  output out_item_t        out_item
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0]   cfg_r;
  logic [LABEL_W-1:0] labels_r [MAX_COLS];
  logic [ROW_W-1:0]   prev_bot_r;

  logic [ROW_W-1:0]   fresh_r;
  logic [ROW_W-1:0]   used_r;
  logic [ROW_W-1:0]   mask_r;
  logic [ROW_W-1:0]   rr_r;
  logic [ROW_W-1:0]   dr_r;
  logic [ROW_W-1:0]   right_r;
  logic [ROW_W-1:0]   bot_r;
  logic               last_r;
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      last_idx_r;
  logic [LABEL_W-1:0] left_r;
  logic               closed_r;
  logic               wall_prev_r;
  out_item_t          out_r;

  logic [CFG_W-1:0]     eff_cols;
  logic [ROW_W-1:0]     mask_w;
  logic [ROW_W-1:0]     fresh_w;
  logic [ROW_W-1:0]     used_w;
  logic [LABEL_W-1:0]   free_lbl;
  logic [ROW_IDX_W-1:0] ci;
  logic                 at_last;
  logic [CW-1:0]        nxt_idx;
  logic [LABEL_W-1:0]   lnext;
  logic                 same;
  logic                 join_wall;
  logic                 closed_eff;
  logic                 clr;

  always_comb begin
    if (cfg_r == '0) begin
      eff_cols = CFG_W'(1);
    end else if (cfg_r > MAX_COLS_C) begin
      eff_cols = MAX_COLS_C;
    end else begin
      eff_cols = cfg_r;
    end
  end

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      mask_w[c] = (CFG_W'(c) < eff_cols);
    end
  end

  assign fresh_w = in_item.first_row ? '1 : prev_bot_r;

  // Labels kept from the row above are reserved before fresh ones are handed out.
  always_comb begin
    used_w = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (!fresh_w[c] && mask_w[c]) begin
        used_w[labels_r[c]] = 1'b1;
      end
    end
  end

  assign free_lbl = first_free(used_r);
  assign ci       = ROW_IDX_W'(col_r);
  assign at_last  = (col_r == last_idx_r);
  assign nxt_idx  = at_last ? col_r : CW'(col_r + 1'b1);
  assign lnext    = labels_r[nxt_idx];
  assign same     = (left_r == lnext);

  // The wall right of the last used column always stands.
  assign join_wall  = at_last || (last_r ? same : (same || rr_r[ci]));
  assign closed_eff = closed_r || wall_prev_r;
  assign clr        = !last_r && closed_eff && (join_wall || dr_r[ci]);

  assign status.at_last = at_last;
  assign out_item       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= CFG_COLS_RESET;
      prev_bot_r <= '1;
      for (int k = 0; k < MAX_COLS; k++) begin
        labels_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (cmd.fresh_step && fresh_r[ci]) begin
        labels_r[col_r] <= free_lbl;
      end
      if (cmd.join_step && !join_wall) begin
        for (int k = 0; k < MAX_COLS; k++) begin
          if (mask_r[k] && (labels_r[k] == lnext)) begin
            labels_r[k] <= left_r;
          end
        end
      end
      if (cmd.emit) begin
        prev_bot_r <= last_r ? '1 : (bot_r | ~mask_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fresh_r     <= fresh_w;
      used_r      <= used_w;
      mask_r      <= mask_w;
      last_r      <= in_item.last_row;
      rr_r        <= {1'b0, in_item.right_random};
      dr_r        <= in_item.down_random;
      last_idx_r  <= CW'(eff_cols - 1'b1);
      col_r       <= '0;
      right_r     <= '0;
      bot_r       <= mask_w;
      closed_r    <= 1'b1;
      wall_prev_r <= 1'b0;
    end
    if (cmd.fresh_step) begin
      if (fresh_r[ci]) begin
        used_r[free_lbl] <= 1'b1;
      end
      if (col_r == '0) begin
        left_r <= fresh_r[ci] ? free_lbl : labels_r[0];
      end
      col_r <= at_last ? '0 : CW'(col_r + 1'b1);
    end
    if (cmd.join_step) begin
      right_r[ci] <= join_wall;
      if (clr) begin
        bot_r[ci] <= 1'b0;
      end
      closed_r    <= closed_eff && !clr;
      wall_prev_r <= join_wall;
      left_r      <= join_wall ? lnext : left_r;
      col_r       <= at_last ? '0 : CW'(col_r + 1'b1);
    end
    if (cmd.emit) begin
      out_r.right_walls  <= right_r & mask_r;
      out_r.bottom_walls <= bot_r & mask_r;
    end
  end

endmodule

// ===== rtl/core/emrg_checker.sv =====
// Port-level checks for the Eller maze row generator and their bind to the top level.
module emrg_checker
  import emrg_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_item
);

  // Every row closes the wall right of its last used column.
  a_right_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.right_walls != '0))
    else $error("result item without a right edge wall");

  // The block works on one item at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // A new result only appears while the block is still working on its item.
  a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result item changed or was dropped");

endmodule

bind eller_maze_row_generator emrg_checker u_emrg_checker (.*);
